### rtl/umpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umpq_pkg: shared types and codes of the unsorted max priority queue
// Field widths, command codes and status codes used by the interfaces,
// the entry store and the top level.
// ----------------------------------------------------------------------------
package umpq_pkg;

  localparam int CMD_W     = 2;
  localparam int VAL_W     = 32;
  localparam int IDX_OUT_W = 6;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  typedef logic [CMD_W-1:0]        cmd_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_OUT_W-1:0]    idx_out_t;
  typedef logic [STAT_W-1:0]       status_t;
  typedef logic [CNT_OUT_W-1:0]    cnt_out_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_FIND   = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

### rtl/umpq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umpq_if: command and result channels of the unsorted max priority queue
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface umpq_in_if;
  import umpq_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  value_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface umpq_out_if;
  import umpq_pkg::*;

  logic     valid;
  logic     ready;
  value_t   max_value;
  idx_out_t max_index;
  status_t  status;
  cnt_out_t count;
  logic     empty_flag;

  modport source (output valid, output max_value, output max_index, output status,
                  output count, output empty_flag, input ready);
  modport sink   (input valid, input max_value, input max_index, input status,
                  input count, input empty_flag, output ready);
endinterface

### rtl/unsorted_max_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue: max priority queue over an unsorted store
// Insert appends, find-max scans the store, delete-max scans and then
// closes the gap by shifting the later entries down one place.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   in_item   sink       valid / ready      command, value
//   out_item  source     valid / ready      max_value, max_index, status,
//                                           count, empty_flag
//
// Find and delete-max scan every entry through the single read port of the
// entry memory, one entry per cycle; delete-max shifts only when the
// maximum is not the last entry.
// Reset clears the count and the control state; memory contents are
// never cleared, since only entries below the count are read.
// A new item is taken whenever the sequencer is idle, even while the last
// result still waits in the output register; the next result then holds.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  umpq_in_if.sink    in_item,
  umpq_out_if.source out_item
);
  import umpq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;  // issue one read per entry
  localparam logic [2:0] S_SDRAIN  = 3'd2;  // last scan read returns
  localparam logic [2:0] S_SDONE   = 3'd3;  // maximum known, pick next step
  localparam logic [2:0] S_SHIFT   = 3'd4;  // read j, write j-1
  localparam logic [2:0] S_SHDRAIN = 3'd5;  // last shift write
  localparam logic [2:0] S_FIN     = 3'd6;  // wait for the output register

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] last_idx;
  logic          full;
  logic          accept;
  logic          out_load;

  // memory port
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  value_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  value_t        wr_data;

  // read tracking: address issued last cycle and whether a read was issued
  logic          rv_r;
  logic [IW-1:0] ra_r;

  cmd_t          cmd_r;
  value_t        best_r;
  logic [IW-1:0] best_idx_r;
  value_t        res_val_r;
  logic [IW-1:0] res_idx_r;
  status_t       res_stat_r;

  logic          out_valid_r;
  value_t        out_val_r;
  idx_out_t      out_idx_r;
  status_t       out_stat_r;
  cnt_out_t      out_cnt_r;
  logic          out_empty_r;

  logic [IW+IDX_OUT_W-1:0] idx_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign full     = (count_r >= CW'(CAPACITY));
  assign last_idx = IW'(count_r - CW'(1));
  assign in_item.ready = (state_r == S_IDLE);
  assign accept   = in_item.valid && in_item.ready;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_item.ready);

  // index and count are reported modulo their field widths
  assign idx_ext = {{IDX_OUT_W{1'b0}}, res_idx_r};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_r};

  umpq_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: drive the memory port and pick the next state.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    wr_en     = 1'b0;
    wr_addr   = ra_r - IW'(1);   // shift: entry read last cycle moves down one
    wr_data   = rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.command == CMD_INSERT) begin
            // append at the tail unless full; a dropped insert changes nothing
            if (!full) begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IW-1:0];
              wr_data   = in_item.value;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_FIN;
          end else if (in_item.command == CMD_FIND || in_item.command == CMD_DELETE) begin
            if (count_r == '0) begin
              state_nxt = S_FIN;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (ptr_r == last_idx) begin
          state_nxt = S_SDRAIN;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end
      S_SDRAIN: begin
        state_nxt = S_SDONE;
      end
      S_SDONE: begin
        if (cmd_r == CMD_FIND) begin
          state_nxt = S_FIN;
        end else if (best_idx_r == last_idx) begin
          // maximum sits at the tail: drop it, nothing to shift
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          ptr_nxt   = best_idx_r + IW'(1);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        rd_en = 1'b1;
        wr_en = rv_r;
        if (ptr_r == last_idx) begin
          state_nxt = S_SHDRAIN;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end
      S_SHDRAIN: begin
        wr_en     = rv_r;
        count_nxt = count_r - CW'(1);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    ra_r  <= rd_addr;
    if (accept) begin
      cmd_r     <= in_item.command;
      res_val_r <= '0;
      res_idx_r <= '0;
      if (in_item.command == CMD_INSERT && full) begin
        res_stat_r <= STAT_FULL;
      end else if ((in_item.command == CMD_FIND || in_item.command == CMD_DELETE)
                   && count_r == '0) begin
        res_stat_r <= STAT_EMPTY;
      end else begin
        res_stat_r <= STAT_OK;
      end
    end
    // running maximum; strict compare keeps the first occurrence
    if (rv_r && (state_r == S_SCAN || state_r == S_SDRAIN)) begin
      if (ra_r == '0 || rd_data > best_r) begin
        best_r     <= rd_data;
        best_idx_r <= ra_r;
      end
    end
    if (state_r == S_SDONE) begin
      res_val_r <= best_r;
      res_idx_r <= best_idx_r;
    end
    if (out_load) begin
      out_val_r   <= res_val_r;
      out_idx_r   <= idx_ext[IDX_OUT_W-1:0];
      out_stat_r  <= res_stat_r;
      out_cnt_r   <= cnt_ext[CNT_OUT_W-1:0];
      out_empty_r <= (count_r == '0);
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.max_value  = out_val_r;
  assign out_item.max_index  = out_idx_r;
  assign out_item.status     = out_stat_r;
  assign out_item.count      = out_cnt_r;
  assign out_item.empty_flag = out_empty_r;

  // The store never holds more entries than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // The scan only reads; no write may disturb the entries under inspection.
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SDRAIN || state_r == S_SDONE) |-> !wr_en)
    else $error("memory write during scan");

  // A failed command reports no value and no index.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.status != STAT_OK)
      |-> (out_item.max_value == '0 && out_item.max_index == '0))
    else $error("error result carries a value");

  // A new result enters the output register only from the finish state.
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside finish state");

  // Shift writes trail the read pointer by two places, so no entry is
  // overwritten before it has been read.
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_en) |-> (ptr_r == wr_addr + IW'(2)))
    else $error("shift write overtakes read");

endmodule

### rtl/umpq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umpq_store: entry memory of the priority queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module umpq_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  umpq_pkg::value_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output umpq_pkg::value_t rd_data
);
  import umpq_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
